>>> design/ist_pkg.sv
package ist_pkg;

   localparam int MAX_RANGES = 64;
   // One pass can add one range before a later pass merges it away again.
   localparam int SLOTS      = MAX_RANGES + 2;
   localparam int BANKS      = 3;
   localparam int DEPTH      = BANKS * SLOTS;
   localparam int CNT_W      = $clog2(SLOTS + 1);
   localparam int ADDR_W     = $clog2(DEPTH);

   localparam logic [63:0] VAL_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

   localparam logic [1:0] CMD_QUERY    = 2'd0;
   localparam logic [1:0] CMD_INSERT   = 2'd1;
   localparam logic [1:0] CMD_ERASE    = 2'd2;
   localparam logic [1:0] CMD_SIMPLIFY = 2'd3;

   typedef enum logic [1:0] {
      OP_INS,
      OP_ERS,
      OP_SMP
   } op_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [63:0] range_first;
      logic [63:0] range_last;
      logic [6:0]  level;
   } req_type;

   typedef struct packed {
      logic       overlaps;
      logic       covers;
      logic       inside_res;
      logic       is_empty;
      logic       is_full;
      logic [6:0] range_count;
      logic       status;
   } rsp_type;

   // Inclusive bounds of one range.
   typedef struct packed {
      logic [63:0] lo;
      logic [63:0] hi;
   } seg_type;

   // Range held back by a pass: the merged range of an insert or the open
   // range of a simplify.
   typedef struct packed {
      logic    flag;
      seg_type x;
   } stream_type;

   typedef struct packed {
      logic       e1_v;
      seg_type    e1;
      logic       e2_v;
      seg_type    e2;
      stream_type st;
   } step_out_type;

endpackage

>>> design/ist_step.sv
module ist_step import ist_pkg::*; (
   input  op_type       op,
   input  seg_type      elem,
   input  seg_type      piece,
   input  logic [63:0]  mask,
   input  stream_type   st_in,
   output step_out_type out
);

   logic [63:0] s_lo;
   logic [63:0] u_hi;
   logic        below;
   logic        touches;
   logic        joins;

   assign s_lo    = elem.lo & ~mask;
   assign u_hi    = elem.hi | mask;
   assign below   = (piece.lo != 64'd0) && (elem.hi < piece.lo - 64'd1);
   assign touches = !((piece.hi != VAL_MAX) && (elem.lo > piece.hi + 64'd1));
   assign joins   = (st_in.x.hi == VAL_MAX) || (s_lo <= st_in.x.hi + 64'd1);

   always_comb begin
      out      = '0;
      out.st   = st_in;
      unique case (op)
         OP_INS: begin
            if (st_in.flag && below) begin
               out.e1_v = 1'b1;
               out.e1   = elem;
            end else if (st_in.flag && touches) begin
               if (elem.lo < st_in.x.lo) out.st.x.lo = elem.lo;
               if (elem.hi > st_in.x.hi) out.st.x.hi = elem.hi;
            end else if (st_in.flag) begin
               out.e1_v    = 1'b1;
               out.e1      = st_in.x;
               out.e2_v    = 1'b1;
               out.e2      = elem;
               out.st.flag = 1'b0;
            end else begin
               out.e1_v = 1'b1;
               out.e1   = elem;
            end
         end
         OP_ERS: begin
            if (elem.hi < piece.lo || elem.lo > piece.hi) begin
               out.e1_v = 1'b1;
               out.e1   = elem;
            end else begin
               if (elem.lo < piece.lo) begin
                  out.e1_v  = 1'b1;
                  out.e1.lo = elem.lo;
                  out.e1.hi = piece.lo - 64'd1;
               end
               if (elem.hi > piece.hi) begin
                  out.e2_v  = 1'b1;
                  out.e2.lo = piece.hi + 64'd1;
                  out.e2.hi = elem.hi;
               end
            end
         end
         OP_SMP: begin
            if (st_in.flag && joins) begin
               if (u_hi > st_in.x.hi) out.st.x.hi = u_hi;
            end else begin
               out.e1_v    = st_in.flag;
               out.e1      = st_in.x;
               out.st.flag = 1'b1;
               out.st.x.lo = s_lo;
               out.st.x.hi = u_hi;
            end
         end
         default: out = '0;
      endcase
   end

endmodule

>>> design/interval_set_table.sv
// Channel     Ports                       Direction  Beat
// request     start, busy, req_item       in         start high while busy low
// response    rsp_strobe, rsp_item        out        one cycle with rsp_strobe high
//
// An update pass reads each stored range in turn, writes one more range for each
// range that an erase splits, and then closes the pass (one or two passes); the
// answering pass then reads each committed range. The range memory is read once
// per cycle.
// Reset is synchronous and active high and leaves an empty set.
// The response beat cannot be stalled; busy falls in the cycle it appears.
module interval_set_table import ist_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   typedef enum logic [3:0] {
      S_IDLE, S_FILL, S_PRD, S_PPR, S_PPR2, S_PEND, S_CHK, S_QRD, S_QPR, S_QEND
   } state_type;

   // The range memory holds three banks: the committed set and two scratch
   // banks, so an update that overflows leaves the committed bank intact.
   seg_type mem [DEPTH];
   seg_type rdata_ff;

   state_type        state_ff;
   logic [1:0]       cur_ff, src_ff, dst_ff;
   logic [CNT_W-1:0] used_ff, idx_ff, wn_ff, srcn_ff;
   logic             pass_ff, npass_ff;
   op_type           op_ff;
   logic [63:0]      mask_ff;
   seg_type          pc_ff [2];
   logic [1:0]       np_ff;
   stream_type       st_ff;
   seg_type          sv_ff;
   logic             ov_ff, ins_ff, status_ff;
   logic [1:0]       cov_ff;
   seg_type          first_ff;
   logic             rsp_strobe_ff;
   rsp_type          rsp_ff;

   logic             accept;
   seg_type          in_pc [2];
   logic [1:0]       in_np;
   step_out_type     step;
   logic             wr_intent;
   seg_type          wr_data;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic             full;

   function automatic logic [1:0] next_bank(input logic [1:0] b);
      return (b == 2'd2) ? 2'd0 : b + 2'd1;
   endfunction

   function automatic logic [ADDR_W-1:0] bank_base(input logic [1:0] b);
      return ADDR_W'(b) * ADDR_W'(SLOTS);
   endfunction

   function automatic stream_type stream_init(input op_type o, input seg_type p);
      stream_type s;
      s      = '0;
      s.flag = (o == OP_INS);
      s.x    = p;
      return s;
   endfunction

   assign accept = start && !busy;
   assign busy   = (state_ff != S_IDLE);

   // Split the item range into inclusive pieces: none for the full range,
   // two when it wraps through the top of the value space.
   always_comb begin
      in_pc[0] = '0;
      in_pc[1] = '0;
      if (req_item.range_first == req_item.range_last) begin
         in_np = 2'd0;
      end else if (req_item.range_last == 64'd0 ||
                   req_item.range_first < req_item.range_last) begin
         in_np       = 2'd1;
         in_pc[0].lo = req_item.range_first;
         in_pc[0].hi = req_item.range_last - 64'd1;
      end else begin
         in_np       = 2'd2;
         in_pc[0].lo = 64'd0;
         in_pc[0].hi = req_item.range_last - 64'd1;
         in_pc[1].lo = req_item.range_first;
         in_pc[1].hi = VAL_MAX;
      end
   end

   ist_step u_step (
      .op    (op_ff),
      .elem  (rdata_ff),
      .piece (pc_ff[pass_ff]),
      .mask  (mask_ff),
      .st_in (st_ff),
      .out   (step)
   );

   always_comb begin
      wr_intent = 1'b0;
      wr_data   = step.e1;
      unique case (state_ff)
         S_PPR:   wr_intent = step.e1_v;
         S_PPR2: begin
            wr_intent = 1'b1;
            wr_data   = sv_ff;
         end
         S_PEND: begin
            wr_intent = st_ff.flag;
            wr_data   = st_ff.x;
         end
         default: wr_intent = 1'b0;
      endcase
   end

   assign wr_addr = bank_base(dst_ff) + ADDR_W'(wn_ff);
   assign rd_addr = (state_ff == S_QRD) ? bank_base(cur_ff) + ADDR_W'(idx_ff)
                                        : bank_base(src_ff) + ADDR_W'(idx_ff);
   assign full    = (used_ff == CNT_W'(1)) && (first_ff.lo == 64'd0) &&
                    (first_ff.hi == VAL_MAX);

   always_ff @(posedge clock) begin
      rdata_ff <= mem[rd_addr];
      if (state_ff == S_FILL) begin
         mem[bank_base(next_bank(cur_ff))] <= '{lo: 64'd0, hi: VAL_MAX};
      end else if (wr_intent && wn_ff < CNT_W'(SLOTS)) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cur_ff        <= 2'd0;
         used_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  pc_ff[0]  <= in_pc[0];
                  pc_ff[1]  <= in_pc[1];
                  np_ff     <= in_np;
                  status_ff <= 1'b0;
                  idx_ff    <= '0;
                  wn_ff     <= '0;
                  pass_ff   <= 1'b0;
                  src_ff    <= cur_ff;
                  dst_ff    <= next_bank(cur_ff);
                  srcn_ff   <= used_ff;
                  mask_ff   <= (64'd1 << req_item.level[5:0]) - 64'd1;
                  state_ff  <= S_QRD;
                  unique case (req_item.command)
                     CMD_INSERT: begin
                        op_ff    <= OP_INS;
                        npass_ff <= (in_np == 2'd2);
                        st_ff    <= stream_init(OP_INS, in_pc[0]);
                        state_ff <= (in_np == 2'd0) ? S_FILL : S_PRD;
                     end
                     CMD_ERASE: begin
                        op_ff    <= OP_ERS;
                        npass_ff <= (in_np == 2'd2);
                        st_ff    <= stream_init(OP_ERS, in_pc[0]);
                        if (in_np == 2'd0) begin
                           used_ff <= '0;
                        end else begin
                           state_ff <= S_PRD;
                        end
                     end
                     CMD_SIMPLIFY: begin
                        op_ff    <= OP_SMP;
                        npass_ff <= 1'b0;
                        st_ff    <= stream_init(OP_SMP, in_pc[0]);
                        if (used_ff != '0 && req_item.level != 7'd0) begin
                           state_ff <= (req_item.level >= 7'd64) ? S_FILL : S_PRD;
                        end
                     end
                     default: state_ff <= S_QRD;
                  endcase
               end
            end
            S_FILL: begin
               cur_ff   <= next_bank(cur_ff);
               used_ff  <= CNT_W'(1);
               state_ff <= S_QRD;
            end
            S_PRD: begin
               state_ff <= (idx_ff == srcn_ff) ? S_PEND : S_PPR;
            end
            S_PPR: begin
               st_ff  <= step.st;
               idx_ff <= idx_ff + CNT_W'(1);
               if (step.e1_v && wn_ff < CNT_W'(SLOTS)) wn_ff <= wn_ff + CNT_W'(1);
               sv_ff  <= step.e2;
               if (step.e2_v) begin
                  state_ff <= step.e1_v ? S_PPR2 : S_PRD;
                  if (!step.e1_v) begin
                     // Only the upper remnant of an erase: write it straight
                     // away by parking it as the saved range.
                     state_ff <= S_PPR2;
                  end
               end else begin
                  state_ff <= S_PRD;
               end
            end
            S_PPR2: begin
               if (wn_ff < CNT_W'(SLOTS)) wn_ff <= wn_ff + CNT_W'(1);
               state_ff <= S_PRD;
            end
            S_PEND: begin
               if (st_ff.flag && wn_ff < CNT_W'(SLOTS)) wn_ff <= wn_ff + CNT_W'(1);
               if (npass_ff && !pass_ff) begin
                  pass_ff  <= 1'b1;
                  src_ff   <= dst_ff;
                  dst_ff   <= next_bank(dst_ff);
                  srcn_ff  <= wn_ff + CNT_W'(st_ff.flag);
                  wn_ff    <= '0;
                  idx_ff   <= '0;
                  st_ff    <= stream_init(op_ff, pc_ff[1]);
                  state_ff <= S_PRD;
               end else begin
                  state_ff <= S_CHK;
               end
            end
            S_CHK: begin
               if (wn_ff > CNT_W'(MAX_RANGES)) begin
                  status_ff <= 1'b1;
               end else begin
                  cur_ff  <= dst_ff;
                  used_ff <= wn_ff;
               end
               state_ff <= S_QRD;
            end
            S_QRD: begin
               state_ff <= (idx_ff == used_ff) ? S_QEND : S_QPR;
            end
            S_QPR: begin
               idx_ff   <= idx_ff + CNT_W'(1);
               state_ff <= S_QRD;
            end
            S_QEND: begin
               rsp_strobe_ff <= 1'b1;
               state_ff      <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
         if (state_ff == S_CHK || state_ff == S_FILL ||
             (state_ff == S_IDLE && accept)) begin
            idx_ff <= '0;
         end
      end
   end

   // Answering pass: accumulate the three answers over the committed set.
   always_ff @(posedge clock) begin
      if (state_ff == S_CHK || state_ff == S_FILL ||
          (state_ff == S_IDLE && accept)) begin
         ov_ff  <= 1'b0;
         cov_ff <= 2'b00;
         ins_ff <= 1'b1;
      end else if (state_ff == S_QPR) begin
         if (idx_ff == '0) first_ff <= rdata_ff;
         for (int p = 0; p < 2; p++) begin
            if (2'(p) < np_ff) begin
               if (rdata_ff.lo <= pc_ff[p].hi && rdata_ff.hi >= pc_ff[p].lo) ov_ff <= 1'b1;
               if (rdata_ff.lo <= pc_ff[p].lo && rdata_ff.hi >= pc_ff[p].hi) cov_ff[p] <= 1'b1;
            end
         end
         if (!((np_ff >= 2'd1 && rdata_ff.lo >= pc_ff[0].lo && rdata_ff.hi <= pc_ff[0].hi) ||
               (np_ff == 2'd2 && rdata_ff.lo >= pc_ff[1].lo && rdata_ff.hi <= pc_ff[1].hi)))
            ins_ff <= 1'b0;
      end
      if (state_ff == S_QEND) begin
         rsp_ff.is_empty    <= (used_ff == '0);
         rsp_ff.is_full     <= full;
         rsp_ff.range_count <= 7'(used_ff);
         rsp_ff.status      <= status_ff;
         if (np_ff == 2'd0) begin
            rsp_ff.overlaps   <= (used_ff != '0);
            rsp_ff.covers     <= full;
            rsp_ff.inside_res <= 1'b1;
         end else begin
            rsp_ff.overlaps   <= ov_ff;
            rsp_ff.covers     <= (cov_ff[0] && (np_ff == 2'd1 || cov_ff[1])) || full;
            rsp_ff.inside_res <= ins_ff;
         end
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy) else $error("accepted item did not raise busy");
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy) else $error("response beat while still working");
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_W'(MAX_RANGES)) else $error("committed range count too large");
   a_bank_apart: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PPR) |-> (dst_ff != cur_ff))
      else $error("update pass writes the committed bank");

endmodule

>>> dv/interval_set_checker.sv
module interval_set_checker import ist_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_item,
   input  logic    rsp_strobe,
   input  rsp_type rsp_item,
   output int      error_count,
   output int      answers_pending
);

   // Committed set and working copy, both with inclusive bounds.
   logic [63:0] set_lo[$], set_hi[$];
   logic [63:0] wk_lo[$], wk_hi[$];
   logic [63:0] nx_lo[$], nx_hi[$];
   rsp_type     answer_queue[$];

   assign answers_pending = answer_queue.size();

   function automatic void push_seg(logic [63:0] lo, logic [63:0] hi);
      nx_lo = {nx_lo, lo};
      nx_hi = {nx_hi, hi};
   endfunction

   function automatic void adopt_next();
      wk_lo = nx_lo;
      wk_hi = nx_hi;
      nx_lo = {};
      nx_hi = {};
   endfunction

   function automatic void add_span(logic [63:0] a, logic [63:0] b);
      int i;
      logic [63:0] ms, me;
      i = 0;
      ms = a;
      me = b;
      while (i < wk_lo.size() && a != 0 && wk_hi[i] < a - 1) begin
         push_seg(wk_lo[i], wk_hi[i]);
         i++;
      end
      while (i < wk_lo.size() && !(b != VAL_MAX && wk_lo[i] > b + 1)) begin
         if (wk_lo[i] < ms) ms = wk_lo[i];
         if (wk_hi[i] > me) me = wk_hi[i];
         i++;
      end
      push_seg(ms, me);
      while (i < wk_lo.size()) begin
         push_seg(wk_lo[i], wk_hi[i]);
         i++;
      end
      adopt_next();
   endfunction

   function automatic void cut_span(logic [63:0] a, logic [63:0] b);
      for (int i = 0; i < wk_lo.size(); i++) begin
         if (wk_hi[i] < a || wk_lo[i] > b) begin
            push_seg(wk_lo[i], wk_hi[i]);
         end else begin
            if (wk_lo[i] < a) push_seg(wk_lo[i], a - 1);
            if (wk_hi[i] > b) push_seg(b + 1, wk_hi[i]);
         end
      end
      adopt_next();
   endfunction

   function automatic void coarsen(logic [6:0] lvl);
      logic [63:0] m, s, u;
      int k;
      if (wk_lo.size() == 0 || lvl == 0) return;
      if (lvl >= 64) begin
         wk_lo = {64'd0};
         wk_hi = {VAL_MAX};
         return;
      end
      m = (64'd1 << lvl) - 1;
      for (int i = 0; i < wk_lo.size(); i++) begin
         s = wk_lo[i] & ~m;
         u = wk_hi[i] | m;
         k = nx_lo.size();
         if (k > 0 && (nx_hi[k-1] == VAL_MAX || s <= nx_hi[k-1] + 1)) begin
            if (u > nx_hi[k-1]) nx_hi[k-1] = u;
         end else begin
            push_seg(s, u);
         end
      end
      adopt_next();
   endfunction

   function automatic rsp_type predict_answer(req_type r);
      rsp_type     a;
      logic [63:0] plo[2], phi[2];
      int          np;
      logic        full, covered, in_piece;
      a = '0;
      if (r.range_first == r.range_last) begin
         np = 0;
      end else if (r.range_last == 0 || r.range_first < r.range_last) begin
         np = 1;
         plo[0] = r.range_first;
         phi[0] = r.range_last - 1;
      end else begin
         np = 2;
         plo[0] = 0;
         phi[0] = r.range_last - 1;
         plo[1] = r.range_first;
         phi[1] = VAL_MAX;
      end
      wk_lo = set_lo;
      wk_hi = set_hi;
      case (r.command)
         CMD_INSERT: begin
            if (np == 0) begin
               wk_lo = {64'd0};
               wk_hi = {VAL_MAX};
            end
            for (int p = 0; p < np; p++) add_span(plo[p], phi[p]);
         end
         CMD_ERASE: begin
            if (np == 0) begin
               wk_lo = {};
               wk_hi = {};
            end
            for (int p = 0; p < np; p++) cut_span(plo[p], phi[p]);
         end
         CMD_SIMPLIFY: coarsen(r.level);
         default: ;
      endcase
      if (wk_lo.size() > MAX_RANGES) begin
         a.status = 1'b1;
      end else begin
         set_lo = wk_lo;
         set_hi = wk_hi;
      end
      full = set_lo.size() == 1 && set_lo[0] == 0 && set_hi[0] == VAL_MAX;
      a.covers = 1'b1;
      a.inside_res = 1'b1;
      if (np == 0) begin
         a.overlaps = set_lo.size() != 0;
         a.covers = full;
      end else begin
         for (int p = 0; p < np; p++) begin
            covered = 1'b0;
            foreach (set_lo[i]) begin
               if (set_lo[i] <= phi[p] && set_hi[i] >= plo[p]) a.overlaps = 1'b1;
               if (set_lo[i] <= plo[p] && set_hi[i] >= phi[p]) covered = 1'b1;
            end
            if (!covered) a.covers = 1'b0;
         end
         foreach (set_lo[i]) begin
            in_piece = 1'b0;
            for (int p = 0; p < np; p++)
               if (set_lo[i] >= plo[p] && set_hi[i] <= phi[p]) in_piece = 1'b1;
            if (!in_piece) a.inside_res = 1'b0;
         end
         if (full) a.covers = 1'b1;
      end
      a.is_empty = set_lo.size() == 0;
      a.is_full = full;
      a.range_count = 7'(set_lo.size());
      return a;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         set_lo = {};
         set_hi = {};
         answer_queue = {};
         error_count <= 0;
      end else begin
         if (rsp_strobe) begin
            if (answer_queue.size() == 0) begin
               $error("Response beat arrived with no answer outstanding.");
               error_count <= error_count + 1;
            end else begin
               want = answer_queue.pop_front();
               if (want != rsp_item) error_count <= error_count + 1;
               if (want.overlaps != rsp_item.overlaps)
                  $error("overlaps: expected %0d, got %0d", want.overlaps, rsp_item.overlaps);
               if (want.covers != rsp_item.covers)
                  $error("covers: expected %0d, got %0d", want.covers, rsp_item.covers);
               if (want.inside_res != rsp_item.inside_res)
                  $error("inside_res: expected %0d, got %0d",
                         want.inside_res, rsp_item.inside_res);
               if (want.is_empty != rsp_item.is_empty)
                  $error("is_empty: expected %0d, got %0d", want.is_empty, rsp_item.is_empty);
               if (want.is_full != rsp_item.is_full)
                  $error("is_full: expected %0d, got %0d", want.is_full, rsp_item.is_full);
               if (want.range_count != rsp_item.range_count)
                  $error("range_count: expected %0d, got %0d",
                         want.range_count, rsp_item.range_count);
               if (want.status != rsp_item.status)
                  $error("status: expected %0d, got %0d", want.status, rsp_item.status);
            end
         end
         if (start && !busy) answer_queue = {answer_queue, predict_answer(req_item)};
      end
   end

endmodule

>>> dv/interval_set_table_test.sv
module interval_set_table_test;
   import ist_pkg::*;

   // The table answers one beat per command after a variable number of
   // cycles, so the stimulus waits on busy and the checker pairs answers
   // with its own predictions in order.
   localparam int RANDOM_ITEMS = 1500;
   localparam int IDLE_LIMIT   = 20000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_strobe;
   rsp_type rsp_item;
   int      error_count;
   int      answers_pending;
   int      quiet_cycles = 0;

   always #10 clock = ~clock;

   interval_set_table dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_strobe(rsp_strobe), .rsp_item(rsp_item)
   );

   interval_set_checker checker_inst (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_strobe(rsp_strobe), .rsp_item(rsp_item),
      .error_count(error_count), .answers_pending(answers_pending)
   );

   // The watchdog counts cycles in which neither channel moves a beat, with a
   // limit that is generous even for the slowest item.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // Values are drawn mostly from a narrow window near zero, so that ranges
   // collide, merge and split often enough to fill the table, with some
   // taken from the top of the space and some wholly at random.
   function automatic logic [63:0] pick_value();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 6) return 64'($urandom_range(0, 60000));
      if (sel == 6) return VAL_MAX - 64'($urandom_range(0, 300));
      if (sel == 7) return 64'($urandom_range(0, 5));
      return {$urandom, $urandom};
   endfunction

   function automatic req_type random_command();
      req_type r;
      int      sel, w;
      sel = $urandom_range(0, 99);
      r.command = sel < 45 ? CMD_INSERT : sel < 70 ? CMD_ERASE :
                  sel < 85 ? CMD_QUERY : CMD_SIMPLIFY;
      r.range_first = pick_value();
      w = $urandom_range(0, 9);
      // Narrow ranges keep the table crowded; the rest are anything at all.
      if (w < 7) r.range_last = r.range_first + 64'($urandom_range(1, 60));
      else if (w < 9) r.range_last = pick_value();
      else r.range_last = r.range_first;
      // Simplify rarely wipes out the crowding, so low levels dominate.
      r.level = $urandom_range(0, 9) < 8 ? 7'($urandom_range(0, 6))
                                         : 7'($urandom_range(0, 127));
      if (r.command == CMD_SIMPLIFY && $urandom_range(0, 3) != 0) r.level = 7'($urandom_range(0, 3));
      return r;
   endfunction

   // One beat: the command is presented at an edge and held until the edge
   // at which busy is low. Start is left high when the next beat follows
   // at once, so it is never lowered and raised within one time step.
   task automatic send_beat(req_type r, int idle_pct);
      start <= 1'b1;
      req_item <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         req_item <= random_command();
         do @(posedge clock); while ($urandom_range(0, 99) < idle_pct);
      end
   endtask

   function automatic req_type make_cmd(logic [1:0] c, logic [63:0] f, logic [63:0] l,
                                        logic [6:0] lvl);
      req_type r;
      r.command = c;
      r.range_first = f;
      r.range_last = l;
      r.level = lvl;
      return r;
   endfunction

   initial begin
      req_type directed[$];
      int      idle_pct;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats: the empty set, the full range both ways, the ends of
      // the value space, a wrapping range and the simplify corner cases.
      directed = '{
         make_cmd(CMD_QUERY,    64'd5, 64'd5, 7'd0),
         make_cmd(CMD_SIMPLIFY, 64'd0, 64'd9, 7'd64),
         make_cmd(CMD_INSERT,   64'd7, 64'd7, 7'd0),
         make_cmd(CMD_QUERY,    64'd1, 64'd2, 7'd0),
         make_cmd(CMD_ERASE,    VAL_MAX, VAL_MAX, 7'd0),
         make_cmd(CMD_INSERT,   64'd0, 64'd1, 7'd0),
         make_cmd(CMD_INSERT,   VAL_MAX, 64'd0, 7'd0),
         make_cmd(CMD_INSERT,   64'd100, 64'd200, 7'd127),
         make_cmd(CMD_INSERT,   64'd200, 64'd300, 7'd0),
         make_cmd(CMD_QUERY,    VAL_MAX - 64'd3, 64'd2, 7'd0),
         make_cmd(CMD_ERASE,    64'd150, 64'd160, 7'd0),
         make_cmd(CMD_SIMPLIFY, 64'd0, 64'd0, 7'd0),
         make_cmd(CMD_SIMPLIFY, 64'd0, 64'd1, 7'd5),
         make_cmd(CMD_INSERT,   VAL_MAX - 64'd10, 64'd20, 7'd0),
         make_cmd(CMD_ERASE,    VAL_MAX, 64'd1, 7'd0),
         make_cmd(CMD_QUERY,    64'd0, 64'd0, 7'd0),
         make_cmd(CMD_SIMPLIFY, 64'd3, 64'd4, 7'd63),
         make_cmd(CMD_SIMPLIFY, 64'd3, 64'd4, 7'd127),
         make_cmd(CMD_ERASE,    64'd10, 64'd20, 7'd0),
         make_cmd(CMD_ERASE,    64'd0, 64'd0, 7'd0),
         make_cmd(CMD_SIMPLIFY, 64'd0, 64'd0, 7'd100)
      };
      foreach (directed[i]) send_beat(directed[i], 0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         idle_pct = n < RANDOM_ITEMS / 3 ? 28 : n < 2 * RANDOM_ITEMS / 3 ? 63 : 0;
         // Halfway through, the sender holds off until the table has drained.
         if (n == RANDOM_ITEMS / 2) begin
            start <= 1'b0;
            @(posedge clock);
            while (answers_pending != 0) @(posedge clock);
         end
         send_beat(random_command(), idle_pct);
      end
      start <= 1'b0;

      while (answers_pending != 0) @(posedge clock);
      repeat (700) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

>>> files.f
design/ist_pkg.sv
design/ist_step.sv
design/interval_set_table.sv
dv/interval_set_checker.sv
dv/interval_set_table_test.sv
